[rtl/s256h_pkg.sv]
package s256h_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/sha256_stream_hasher.sv]
// SHA-256 hasher that takes the message one byte per item.
// Input channel: in_valid/in_stall with in_data_byte, in_has_byte and in_last.
// An item with in_has_byte set appends its byte; an item with in_last set
// ends the message, and an item with neither changes nothing.
// Output channel: out_valid/out_stall with out_digest_word, out_word_index
// and out_last_word. A finished message yields eight items, word 0 first.
// Flow control: a byte that does not complete a 64-byte block is taken
// without stalling the input. The byte that completes a block holds off
// the input while the block is compressed: a step to prime the block
// memory read, 64 rounds of the shared round unit, and a step to fold the
// result into the chaining words. A last item then writes the padding one
// byte per cycle up to the end of the block. When the length does not fit,
// that padding is at most 8 bytes, followed by a compression and a further
// block of padding and length. It then runs the final compression and
// presents the digest words one per cycle while out_stall is low.
// While the receiver stalls, the current digest word is held and the input
// stays stalled. After the eighth word is taken the chaining words, fill
// count and bit length return to their initial values.
// Reset (rst_n low, synchronous) puts the block into the same initial
// state; the block buffer memory needs no clearing.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  s256h_pkg::state_t state_r, state_nxt;

  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_phase_r, len_phase_nxt;
  logic        pad_pend_r, pad_pend_nxt;
  logic        final_r, final_nxt;

  logic [31:0] hash_r [8];
  logic [31:0] v_r [8];
  logic [31:0] win_r [16];

  // Block buffer: sixteen big-endian words, written a byte at a time.
  logic [31:0] blk_mem [16];
  logic [31:0] rdata_r;
  logic [3:0]  rd_idx;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic        in_acc;
  logic        len_use;
  logic [7:0]  len_byte;
  logic [31:0] w_sched, w_t, t1, t2;
  logic        do_round, do_fold, do_init, do_prep;

  assign in_stall = (state_r != s256h_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (state_r == s256h_pkg::ST_OUT);
  assign out_digest_word = hash_r[cnt_r[2:0]];
  assign out_word_index  = cnt_r[2:0];
  assign out_last_word   = (cnt_r[2:0] == s256h_pkg::LAST_WORD_IDX);

  // The length field goes out most significant byte first.
  assign len_byte = 8'(bitlen_r >> {3'(3'd7 - fill_r[2:0]), 3'b000});
  assign len_use  = pad_first_r ? (fill_r < s256h_pkg::LEN_POS) : len_phase_r;

  assign w_sched = s256h_pkg::small_sig1(win_r[14]) + win_r[9] +
                   s256h_pkg::small_sig0(win_r[1]) + win_r[0];
  assign w_t = (cnt_r < 6'd16) ? rdata_r : w_sched;
  assign t1 = v_r[7] + s256h_pkg::big_sig1(v_r[4]) +
              ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
              s256h_pkg::round_k(cnt_r) + w_t;
  assign t2 = s256h_pkg::big_sig0(v_r[0]) +
              ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign rd_idx = (state_r == s256h_pkg::ST_PREP) ? 4'd0 : 4'(cnt_r[3:0] + 4'd1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    cnt_nxt       = cnt_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;
    pad_pend_nxt  = pad_pend_r;
    final_nxt     = final_r;
    wr_en    = 1'b0;
    wr_pos   = fill_r;
    wr_byte  = in_data_byte;
    do_round = 1'b0;
    do_fold  = 1'b0;
    do_init  = 1'b0;
    do_prep  = 1'b0;
    case (state_r)
      s256h_pkg::ST_IDLE: begin
        if (in_acc) begin
          pad_first_nxt = 1'b1;
          final_nxt     = 1'b0;
          if (in_has_byte) begin
            wr_en      = 1'b1;
            fill_nxt   = 6'(fill_r + 6'd1);
            bitlen_nxt = 64'(bitlen_r + 64'd8);
            if (fill_r == s256h_pkg::LAST_POS) begin
              state_nxt    = s256h_pkg::ST_PREP;
              pad_pend_nxt = in_last;
            end else if (in_last) begin
              state_nxt = s256h_pkg::ST_PAD;
            end
          end else if (in_last) begin
            state_nxt = s256h_pkg::ST_PAD;
          end
        end
      end
      s256h_pkg::ST_PAD: begin
        wr_en = 1'b1;
        if (pad_first_r) begin
          wr_byte = s256h_pkg::PAD_BYTE;
        end else if (len_use && fill_r >= s256h_pkg::LEN_POS) begin
          wr_byte = len_byte;
        end else begin
          wr_byte = 8'h00;
        end
        pad_first_nxt = 1'b0;
        len_phase_nxt = len_use;
        fill_nxt      = 6'(fill_r + 6'd1);
        if (fill_r == s256h_pkg::LAST_POS) begin
          state_nxt     = s256h_pkg::ST_PREP;
          final_nxt     = len_use;
          pad_pend_nxt  = !len_use;
          len_phase_nxt = 1'b1;
        end
      end
      s256h_pkg::ST_PREP: begin
        do_prep   = 1'b1;
        cnt_nxt   = 6'd0;
        state_nxt = s256h_pkg::ST_ROUND;
      end
      s256h_pkg::ST_ROUND: begin
        do_round = 1'b1;
        cnt_nxt  = 6'(cnt_r + 6'd1);
        if (cnt_r == 6'd63) begin
          state_nxt = s256h_pkg::ST_FOLD;
        end
      end
      s256h_pkg::ST_FOLD: begin
        do_fold = 1'b1;
        cnt_nxt = 6'd0;
        if (final_r) begin
          state_nxt = s256h_pkg::ST_OUT;
        end else if (pad_pend_r) begin
          state_nxt    = s256h_pkg::ST_PAD;
          pad_pend_nxt = 1'b0;
        end else begin
          state_nxt = s256h_pkg::ST_IDLE;
        end
      end
      s256h_pkg::ST_OUT: begin
        if (!out_stall) begin
          if (cnt_r[2:0] == s256h_pkg::LAST_WORD_IDX) begin
            do_init    = 1'b1;
            fill_nxt   = 6'd0;
            bitlen_nxt = 64'd0;
            final_nxt  = 1'b0;
            state_nxt  = s256h_pkg::ST_IDLE;
          end else begin
            cnt_nxt = 6'(cnt_r + 6'd1);
          end
        end
      end
      default: begin
        state_nxt = s256h_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= s256h_pkg::ST_IDLE;
      fill_r      <= 6'd0;
      bitlen_r    <= 64'd0;
      cnt_r       <= 6'd0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
      pad_pend_r  <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      cnt_r       <= cnt_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
      pad_pend_r  <= pad_pend_nxt;
      final_r     <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rdata_r <= blk_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= s256h_pkg::init_hash(3'(i));
      end
    end else if (do_init) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= s256h_pkg::init_hash(3'(i));
      end
    end else if (do_fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_prep) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= hash_r[i];
      end
    end else if (do_round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w_t;
    end
  end

  a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == s256h_pkg::ST_ROUND && cnt_r == 6'd63) |=>
      (state_r == s256h_pkg::ST_FOLD))
    else $error("compression did not end after 64 rounds");

  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=>
      (fill_r == 6'd0 && bitlen_r == 64'd0 && state_r == s256h_pkg::ST_IDLE))
    else $error("state not reinitialized after digest");

  a_out_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest pending");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_has_byte) |=> (fill_r == 6'($past(fill_r) + 6'd1)))
    else $error("fill count did not advance on a byte");

endmodule
